@@ design/tws_pkg.sv @@
// Shared constants, command type and tap helpers for the triangular smoother.
`timescale 1ns / 1ps
`default_nettype none
package tws_pkg;

  localparam int MAX_TAPS    = 32;
  localparam int TAPS_W      = 6;                  // config register width
  localparam int IDX_W       = $clog2(MAX_TAPS);   // delay line index
  localparam int D_W         = 4;                  // lookahead count, up to 15
  localparam int SAMPLE_W    = 16;
  localparam int SEEN_W      = 16;
  localparam int WT_W        = 6;                  // one tap weight
  localparam int PROD_W      = SAMPLE_W + WT_W + 1;
  localparam int ACC_W       = 25;                 // exact weighted sum
  localparam int WS_W        = 10;                 // weight sum, at most 272
  localparam int NUM_W       = ACC_W + 1;          // 2*|acc| + ws
  localparam int Q_W         = 17;                 // quotient bits, q <= 32768
  localparam int DEN_W       = WS_W + 1;           // 2*ws
  localparam int QCNT_W      = $clog2(Q_W);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

  // One accepted word, classified for the back end.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
    logic                       emit;   // output for this word itself
    logic [TAPS_W-1:0]          n;      // effective tap count
    logic [D_W-1:0]             flush;  // trailing zero shifts on last
    logic [D_W-1:0]             skip;   // leading flush shifts without output
  } cmd_t;

  // Clamp the register to 1..MAX_TAPS.
  function automatic logic [TAPS_W-1:0] eff_taps(input logic [TAPS_W-1:0] t);
    logic [TAPS_W-1:0] r;
    r = t;
    if (t == '0) r = TAPS_W'(1);
    else if (t > TAPS_W'(MAX_TAPS)) r = TAPS_W'(MAX_TAPS);
    return r;
  endfunction

  // Lookahead d = n - 1 - n/2.
  function automatic logic [D_W-1:0] lookahead(input logic [TAPS_W-1:0] n);
    logic [TAPS_W-1:0] r;
    r = n - TAPS_W'(1) - (n >> 1);
    return r[D_W-1:0];
  endfunction

endpackage
`default_nettype wire

@@ design/tws_if.sv @@
// Valid/ready stream interfaces for waveform words and smoothed words.
`timescale 1ns / 1ps
`default_nettype none
interface tws_wave_if;
  import tws_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_in;
  modport source (output valid, output sample, output last_in, input ready);
  modport sink (input valid, input sample, input last_in, output ready);
endinterface

interface tws_result_if;
  import tws_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] smoothed;
  logic                       last_out;
  modport source (output valid, output smoothed, output last_out, input ready);
  modport sink (input valid, input smoothed, input last_out, output ready);
endinterface
`default_nettype wire

@@ design/triangular_weighted_smoother.sv @@
// Top level of the triangular weighted moving-average smoother.
//
//  channel  | dir | payload                     | handshake
//  ---------+-----+-----------------------------+------------------------
//  wave     | in  | sample (s16 Q11.4), last_in | valid/ready
//  result   | out | smoothed (s16), last_out    | valid/ready
//  cfg      | in  | cfg_wdata = taps (6 bit)    | cfg_wen, no read-back
//
// Steps: a smoothed word passes through the back end in this order:
//   take the word or shift in a zero, multiply-accumulate over the n
//   effective taps, setup, rounding division, load the output register.
//   Each word ends with a step back to idle and one per skipped zero shift.
// Reset: rst is synchronous; it clears the delay line, position count,
//   queue and output valid flag and sets taps to 1.
// Stalls: the front takes words into a 2-deep queue while the back end
//   works; the back end holds in its output step while result stalls.
`timescale 1ns / 1ps
`default_nettype none
module triangular_weighted_smoother (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wen,
  input  wire logic [tws_pkg::TAPS_W-1:0] cfg_wdata,
  tws_wave_if.sink                        wave,
  tws_result_if.source                    result
);
  import tws_pkg::*;

  logic [TAPS_W-1:0] taps;

  // front -> queue
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;

  // queue -> back
  logic pop_valid;
  logic pop_ready;
  cmd_t pop_cmd;

  // taps register; the user must write it only while the block is idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      taps <= TAPS_W'(1);
    end else if (cfg_wen) begin
      taps <= cfg_wdata;
    end
  end

  // front: position tracking and classification of each word
  tws_front u_front (
    .clk        (clk),
    .rst        (rst),
    .taps       (taps),
    .wave       (wave),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // decoupling queue
  tws_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // back: delay line, MAC, divider, output register
  tws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .result    (result)
  );

`ifndef SYNTHESIS
  // trailing flush only ever follows the last word of a waveform
  a_flush_only_on_last: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (push_cmd.last || push_cmd.flush == '0))
    else $error("flush requested on a word that is not last");

  // skipped flush steps never cover the final flush output
  a_skip_below_flush: assert property (@(posedge clk) disable iff (rst)
    (push_valid && push_cmd.flush != '0) |-> push_cmd.skip < push_cmd.flush)
    else $error("flush would end without its final output");

  // effective tap count stays in range
  a_taps_range: assert property (@(posedge clk) disable iff (rst)
    push_valid |-> (push_cmd.n != '0 && push_cmd.n <= TAPS_W'(MAX_TAPS)))
    else $error("effective tap count out of range");

  // the queue never blocks the front while the back end waits in idle
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop_ready |-> (pop_valid || !push_valid || push_ready))
    else $error("queue blocks the front while the back end waits");
`endif

endmodule
`default_nettype wire

@@ design/tws_front.sv @@
// Front end: accepts waveform words, tracks position, classifies outputs.
`timescale 1ns / 1ps
`default_nettype none
module tws_front (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [tws_pkg::TAPS_W-1:0] taps,
  tws_wave_if.sink                        wave,
  output      logic                       push_valid,
  input  wire logic                       push_ready,
  output      tws_pkg::cmd_t              push_cmd
);
  import tws_pkg::*;

  logic [SEEN_W-1:0] seen_count;
  logic [TAPS_W-1:0] n;
  logic [D_W-1:0]    d;
  logic              emit;
  logic              accept;

  assign n          = eff_taps(taps);
  assign d          = lookahead(n);
  assign emit       = seen_count >= SEEN_W'(d);
  assign push_valid = wave.valid;
  assign wave.ready = push_ready;
  assign accept     = wave.valid && push_ready;

  always_comb begin
    push_cmd        = '0;
    push_cmd.sample = wave.sample;
    push_cmd.last   = wave.last_in;
    push_cmd.emit   = emit;
    push_cmd.n      = n;
    if (wave.last_in) begin
      push_cmd.flush = d;
      // seen_count < d here, so its low bits are exact
      if (!emit) push_cmd.skip = d - seen_count[D_W-1:0] - D_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= '0;
    end else if (accept) begin
      if (wave.last_in) seen_count <= '0;
      else if (seen_count != '1) seen_count <= seen_count + SEEN_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ design/tws_queue.sv @@
// Small command queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module tws_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output      logic          push_ready,
  input  wire tws_pkg::cmd_t push_cmd,
  output      logic          pop_valid,
  input  wire logic          pop_ready,
  output      tws_pkg::cmd_t pop_cmd
);
  import tws_pkg::*;

  cmd_t               entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QFILL_W-1:0] fill;
  logic               do_push;
  logic               do_pop;

  assign push_ready = fill != QFILL_W'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (do_push && !do_pop)      fill <= fill + QFILL_W'(1);
      else if (do_pop && !do_push) fill <= fill - QFILL_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ design/tws_back.sv @@
// Back end: delay line, serial MAC, serial rounding divider, output register.
`timescale 1ns / 1ps
`default_nettype none
module tws_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          pop_valid,
  output      logic          pop_ready,
  input  wire tws_pkg::cmd_t pop_cmd,
  tws_result_if.source       result
);
  import tws_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_NEXT, S_MAC, S_PREP, S_DIV, S_PUT
  } state_t;

  state_t                      state;
  logic signed [SAMPLE_W-1:0]  dline [MAX_TAPS];
  logic [TAPS_W-1:0]           n_reg;
  logic                        last_reg;
  logic [D_W-1:0]              flush_left;
  logic [D_W-1:0]              skip_left;
  logic                        cur_last;
  logic [IDX_W-1:0]            w;
  logic signed [ACC_W-1:0]     acc;
  logic [WS_W-1:0]             ws;
  logic                        neg;
  logic [DEN_W-1:0]            den;
  logic [WS_W-1:0]             rem;
  logic [Q_W-1:0]              low;
  logic [QCNT_W-1:0]           cnt;
  logic                        out_valid;
  logic signed [SAMPLE_W-1:0]  out_smoothed;
  logic                        out_last;

  logic [TAPS_W-1:0]           idx;
  logic [TAPS_W-1:0]           h;
  logic [TAPS_W-1:0]           w_ext;
  logic [WT_W-1:0]             wt;
  logic signed [PROD_W-1:0]    prod;
  logic [ACC_W-1:0]            mag;
  logic [NUM_W-1:0]            num;
  logic [DEN_W-1:0]            trial;
  logic                        ge;
  logic [DEN_W-1:0]            diff;
  logic [Q_W-1:0]              qsigned;
  logic                        mac_done;

  assign pop_ready       = state == S_IDLE;
  assign result.valid    = out_valid;
  assign result.smoothed = out_smoothed;
  assign result.last_out = out_last;

  // tap weight: w+1 on the rising side, h+1 at the odd center, n-w after
  always_comb begin
    w_ext = TAPS_W'(w);
    h     = n_reg >> 1;
    idx   = n_reg - TAPS_W'(1) - w_ext;
    if (w_ext < h)                 wt = WT_W'(w_ext + TAPS_W'(1));
    else if (n_reg[0] && w_ext == h) wt = WT_W'(h + TAPS_W'(1));
    else                           wt = WT_W'(n_reg - w_ext);
  end

  assign prod     = $signed({1'b0, wt}) * dline[idx[IDX_W-1:0]];
  assign mac_done = w_ext == n_reg - TAPS_W'(1);

  // |acc| and the rounding numerator 2|acc| + ws
  assign mag = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign num = {mag, 1'b0} + NUM_W'(ws);

  // one restoring divide step per cycle
  assign trial   = {rem, low[Q_W-1]};
  assign ge      = trial >= den;
  assign diff    = trial - den;
  assign qsigned = neg ? (~low + Q_W'(1)) : low;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      n_reg      <= TAPS_W'(1);
      last_reg   <= 1'b0;
      flush_left <= '0;
      skip_left  <= '0;
      cur_last   <= 1'b0;
      for (int i = 0; i < MAX_TAPS; i++) dline[i] <= '0;
    end else begin
      // in S_PUT a taken word is replaced by the next one
      if (result.ready && state != S_PUT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            dline[0] <= pop_cmd.sample;
            for (int i = 1; i < MAX_TAPS; i++) dline[i] <= dline[i-1];
            n_reg      <= pop_cmd.n;
            last_reg   <= pop_cmd.last;
            flush_left <= pop_cmd.flush;
            skip_left  <= pop_cmd.skip;
            if (pop_cmd.emit) begin
              cur_last <= pop_cmd.last && pop_cmd.flush == '0;
              w        <= '0;
              acc      <= '0;
              ws       <= '0;
              state    <= S_MAC;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          if (flush_left != '0) begin
            dline[0] <= '0;
            for (int i = 1; i < MAX_TAPS; i++) dline[i] <= dline[i-1];
            flush_left <= flush_left - D_W'(1);
            if (skip_left != '0) begin
              skip_left <= skip_left - D_W'(1);
            end else begin
              cur_last <= flush_left == D_W'(1);
              w        <= '0;
              acc      <= '0;
              ws       <= '0;
              state    <= S_MAC;
            end
          end else begin
            if (last_reg) begin
              for (int i = 0; i < MAX_TAPS; i++) dline[i] <= '0;
            end
            state <= S_IDLE;
          end
        end
        S_MAC: begin
          acc <= acc + ACC_W'(prod);
          ws  <= ws + WS_W'(wt);
          if (mac_done) state <= S_PREP;
          else w <= w + IDX_W'(1);
        end
        S_PREP: begin
          neg   <= acc[ACC_W-1];
          den   <= {ws, 1'b0};
          rem   <= WS_W'(num[NUM_W-1:Q_W]);
          low   <= num[Q_W-1:0];
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= ge ? diff[WS_W-1:0] : trial[WS_W-1:0];
          low <= {low[Q_W-2:0], ge};
          cnt <= cnt + QCNT_W'(1);
          if (cnt == QCNT_W'(Q_W - 1)) state <= S_PUT;
        end
        S_PUT: begin
          if (!out_valid || result.ready) begin
            out_valid    <= 1'b1;
            out_smoothed <= qsigned[SAMPLE_W-1:0];
            out_last     <= cur_last;
            state        <= S_NEXT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ verif/tb_triangular_weighted_smoother.sv @@
// Testbench for the triangular weighted smoother: directed and random waveforms, scoreboarded.
`timescale 1ns / 1ps
module tb_triangular_weighted_smoother;
  import tws_pkg::*;

  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int QUIET_LIMIT   = 5000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES = 80;    // back end may still chew on no-output words
  localparam int RANDOM_WORDS  = 290;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Tap settings worth hitting often: zero, the small ones, the top and one below it, and above the top.
  localparam logic [TAPS_W-1:0] EDGE_TAPS [7] = '{6'd0, 6'd1, 6'd2, 6'd31, 6'd32, 6'd33, 6'd63};

  typedef struct {
    logic signed [SAMPLE_W-1:0] smoothed;
    logic                       last;
  } smooth_word_t;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              cfg_wen   = 1'b0;
  logic [TAPS_W-1:0] cfg_wdata = '0;

  tws_wave_if   wave_ch ();
  tws_result_if result_ch ();

  triangular_weighted_smoother dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .wave      (wave_ch),
    .result    (result_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow of the block: last MAX_TAPS samples (index 0 newest), waveform
  // position and the tap register as written.
  logic signed [SAMPLE_W-1:0] wave_hist [MAX_TAPS];
  int unsigned                seen_words;
  logic [TAPS_W-1:0]          taps_reg;
  smooth_word_t               expected_smoothed [$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int random_sent    = 0;
  bit steady_flow    = 1'b0;   // no idling on either side while set
  bit hold_request   = 1'b0;   // pulse: receiver starts a long hold-off

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Register value to tap count: zero acts as one, above the top saturates.
  function automatic int unsigned clamp_taps(logic [TAPS_W-1:0] t);
    if (t == '0) return 1;
    if (int'(t) > MAX_TAPS) return MAX_TAPS;
    return int'(t);
  endfunction

  // Triangle: 1..h rising, h+1 peak for odd n, then falling to 1.
  function automatic int unsigned tap_weight(int unsigned w, int unsigned n);
    int unsigned h;
    h = n / 2;
    if (w < h) return w + 1;
    if (n[0] && w == h) return h + 1;
    return n - w;
  endfunction

  // Weighted mean over the window, oldest sample gets weight index 0.
  // Rounds to nearest, ties away from zero.
  function automatic logic signed [SAMPLE_W-1:0] weighted_mean(int unsigned n);
    longint acc;
    longint wsum;
    longint mag;
    longint q;
    acc  = 0;
    wsum = 0;
    for (int unsigned w = 0; w < n; w++) begin
      acc  += longint'(tap_weight(w, n)) * longint'(wave_hist[n - 1 - w]);
      wsum += longint'(tap_weight(w, n));
    end
    mag = (acc < 0) ? -acc : acc;
    q   = (2 * mag + wsum) / (2 * wsum);
    return SAMPLE_W'((acc < 0) ? -q : q);
  endfunction

  function automatic void shift_hist(logic signed [SAMPLE_W-1:0] v);
    for (int i = MAX_TAPS - 1; i > 0; i--) wave_hist[i] = wave_hist[i - 1];
    wave_hist[0] = v;
  endfunction

  function automatic void clear_history();
    foreach (wave_hist[i]) wave_hist[i] = '0;
    seen_words = 0;
  endfunction

  // Append one expected smoothed word at the tail.
  function automatic void queue_expected(logic signed [SAMPLE_W-1:0] s, bit last);
    smooth_word_t w;
    w.smoothed = s;
    w.last     = last;
    expected_smoothed.insert(expected_smoothed.size(), w);
  endfunction

  // One accepted word: output i needs the lookahead d in hand; a last word
  // flushes the trailing outputs with zero padding, then starts over.
  function automatic void predict_smoothing(logic signed [SAMPLE_W-1:0] s, bit last);
    int unsigned n;
    int unsigned d;
    int unsigned k;
    n = clamp_taps(taps_reg);
    d = n - 1 - n / 2;
    k = seen_words;
    shift_hist(s);
    if (seen_words < 65535) seen_words++;
    if (k >= d) queue_expected(weighted_mean(n), last && d == 0);
    if (last) begin
      for (int unsigned j = 1; j <= d; j++) begin
        shift_hist('0);
        if (k + j >= d) queue_expected(weighted_mean(n), j == d);
      end
      clear_history();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Receiver side: random ready, a long hold-off on request
  // ---------------------------------------------------------------------
  initial begin : drive_ready
    int hold_left;
    hold_left       = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) hold_left = HOLD_CYCLES;
      else if (hold_left > 0) hold_left--;
      if (hold_left > 0) result_ch.ready <= 1'b0;
      else if (steady_flow) result_ch.ready <= 1'b1;
      else result_ch.ready <= ($urandom_range(99) >= 17);
    end
  end

  // Scoreboard: every smoothed word against the oldest expectation.
  always @(posedge clk) begin : check_results
    smooth_word_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_smoothed.size() == 0) begin
        $error("unexpected smoothed word: smoothed %0d last_out %0b",
               result_ch.smoothed, result_ch.last_out);
        mismatch_count++;
      end else begin
        want = expected_smoothed.pop_front();
        if (result_ch.smoothed !== want.smoothed) begin
          $error("smoothed: expected %0d, actual %0d", want.smoothed, result_ch.smoothed);
          mismatch_count++;
        end
        if (result_ch.last_out !== want.last) begin
          $error("last_out: expected %0b, actual %0b", want.last, result_ch.last_out);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: too long without a word moving on either channel.
  always @(posedge clk) begin
    if (rst || (wave_ch.valid && wave_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("triangular_weighted_smoother: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------

  // Offer one word, with a random gap ahead of it; predict on acceptance.
  task automatic send_word(logic signed [SAMPLE_W-1:0] s, bit last);
    if (!steady_flow && $urandom_range(99) < 17) begin
      wave_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 17);
    end
    wave_ch.valid   <= 1'b1;
    wave_ch.sample  <= s;
    wave_ch.last_in <= last;
    do @(posedge clk); while (!wave_ch.ready);
    predict_smoothing(s, last);
  endtask

  // Drop valid, let every expected word come back, then give the back end
  // time to finish words that produce nothing.
  task automatic wait_idle();
    wave_ch.valid <= 1'b0;
    while (expected_smoothed.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_taps(logic [TAPS_W-1:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    taps_reg   = v;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(9))
      6:       return SAMPLE_MAX;
      7:       return SAMPLE_MIN;
      8, 9:    return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_waveform(int len, bit close);
    for (int i = 0; i < len; i++) send_word(random_sample(), close && i == len - 1);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset value of taps (one tap, output equals input), extremes of the sample,
  // and a one-word waveform.
  task automatic test_default_taps();
    send_word(SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MIN, 1'b0);
    send_word('0, 1'b0);
    send_word(-16'sd1, 1'b1);
    send_word(16'sh5A5A, 1'b1);
    wait_idle();
  endtask

  // Full width with waveforms shorter than the lookahead, so every output
  // comes from the flush; then zero taps and taps above the top.
  task automatic test_tap_extremes();
    write_taps(6'd32);
    for (int i = 0; i < 6; i++) send_word(i[0] ? SAMPLE_MIN : SAMPLE_MAX, i == 5);
    wait_idle();
    write_taps(6'd0);
    send_word(SAMPLE_MIN, 1'b0);
    send_word(SAMPLE_MAX, 1'b1);
    wait_idle();
    write_taps(6'd63);
    send_word(SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MIN, 1'b1);
    wait_idle();
  endtask

  // Tap count changed in the middle of a waveform; the delay line keeps
  // all samples, so the wider window still sees the earlier ones.
  task automatic test_taps_midwave();
    write_taps(6'd5);
    for (int i = 0; i < 4; i++) send_word(random_sample(), 1'b0);
    wait_idle();
    write_taps(6'd8);
    for (int i = 0; i < 4; i++) send_word(random_sample(), i == 3);
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering at full rate, so the
  // input queue fills and wave.ready drops.
  task automatic test_backpressure();
    write_taps(6'd32);
    steady_flow  <= 1'b1;
    hold_request <= 1'b1;
    @(posedge clk);
    hold_request <= 1'b0;
    send_waveform(30, 1'b1);
    random_sent += 30;
    wait_idle();
    steady_flow <= 1'b0;
  endtask

  // Phases of random tap settings, each a run of random-length waveforms.
  // A phase may end with its waveform still open, so the next setting lands
  // mid-waveform. Phase 2 runs with no idling at all.
  task automatic test_random_waveforms();
    int  phase;
    int  budget;
    int  len;
    bit  close;
    phase = 0;
    while (random_sent < RANDOM_WORDS) begin
      if ($urandom_range(3) == 0) write_taps(EDGE_TAPS[$urandom_range(6)]);
      else write_taps(TAPS_W'($urandom_range(1, 32)));
      steady_flow <= (phase == 2);
      budget = $urandom_range(15, 40);
      while (budget > 0) begin
        len    = ($urandom_range(9) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 16);
        budget -= len;
        close  = (budget > 0) || ($urandom_range(3) != 0);
        send_waveform(len, close);
        random_sent += len;
      end
      wait_idle();
      phase++;
    end
    steady_flow <= 1'b0;
    // close whatever waveform is still open
    send_word(random_sample(), 1'b1);
    wait_idle();
  endtask

  initial begin
    clear_history();
    taps_reg          = 6'd1;
    wave_ch.valid     = 1'b0;
    wave_ch.sample    = '0;
    wave_ch.last_in   = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_default_taps();
    test_tap_extremes();
    test_taps_midwave();
    test_backpressure();
    test_random_waveforms();

    if (mismatch_count == 0 && expected_smoothed.size() == 0) begin
      $display("triangular_weighted_smoother: match");
    end else begin
      $display("triangular_weighted_smoother: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/tws_pkg.sv
design/tws_if.sv
design/tws_front.sv
design/tws_queue.sv
design/tws_back.sv
design/triangular_weighted_smoother.sv
verif/tb_triangular_weighted_smoother.sv
